[rtl/core/tga_truecolor_rle_decoder_core_defines.svh]
// Assertion macros for the TGA decoder core
`ifndef TGA_TRUECOLOR_RLE_DECODER_CORE_DEFINES_SVH
`define TGA_TRUECOLOR_RLE_DECODER_CORE_DEFINES_SVH
// implication checked on every clock outside reset
`define TGA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define TGA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/tga_pkg.sv]
//------------------------------------------------------------------------------
// tga_pkg
// Shared types and constants of the TGA decoder core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package tga_pkg;
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_ID     = 3'd1;
   localparam logic [2:0] PH_PIXELS = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_ERROR  = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
   localparam logic [1:0] ST_BAD_DEPTH = 2'd2;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_STAT  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] pixel;
      logic [7:0]  run_len;
      logic [31:0] index;
      logic [1:0]  status;
      logic        done;
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic [31:0] pixel_a;
      logic [31:0] pixel_b;
      logic [1:0]  pixel_count;
      logic [31:0] pixel_index;
      logic [1:0]  status;
      logic        image_done;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last;
   } rsp_type;
endpackage

[rtl/core/tga_front.sv]
//------------------------------------------------------------------------------
// tga_front
// Parses header, id and pixel bytes; issues one command per finished event.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tga_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_start_of_file,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output tga_pkg::cmd_type  cmd
);
   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hcnt_ff, hcnt_in;
   logic [7:0]  idl_ff, idl_in;
   logic        coded_ff, coded_in, tok_ff, tok_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [15:0] w_ff, w_in, h_ff, h_in, col_ff, col_in;
   logic [31:0] asm_ff, asm_in, pw_ff, pw_in, rb_ff, rb_in;
   logic [1:0]  bip_ff, bip_in;
   logic [7:0]  pl_ff, pl_in;
   logic        run_ff, run_in;
   // total pixel count, refreshed on every header byte
   logic [31:0] tot_ff, tot_in;
   logic [31:0] rem;
   logic [7:0]  take;
   logic        fire;
   logic        sof;

   assign req_ready = cmd_ready;
   assign fire = req_valid && req_ready;
   assign cmd_valid = fire && cmd.cmd != tga_pkg::CMD_NONE;

   always_comb begin
      logic [2:0]  ph;
      logic [4:0]  hc;
      logic [7:0]  il;
      logic        cd, to;
      logic [2:0]  bp;
      logic [15:0] w, h;
      logic [1:0]  bi;
      logic [31:0] npw;
      logic [31:0] tot;
      logic        stp;
      ph = phase_ff; hc = hcnt_ff; il = idl_ff; cd = coded_ff; to = tok_ff;
      bp = bpp_ff; w = w_ff; h = h_ff;
      asm_in = asm_ff; bi = bip_ff; pl_in = pl_ff; run_in = run_ff; pw_in = pw_ff;
      col_in = col_ff; rb_in = rb_ff;
      stp = 1'b0;
      npw = pw_ff;
      rem = '0;
      take = '0;
      cmd = '0;
      cmd.cmd = tga_pkg::CMD_NONE;
      cmd.last = 1'b1;
      sof = req_start_of_file;
      if (sof) begin
         ph = tga_pkg::PH_HEADER; hc = '0; il = '0; cd = 1'b0; to = 1'b0; bp = '0;
         w = '0; h = '0; asm_in = '0; bi = '0; pl_in = '0; run_in = 1'b0;
         pw_in = '0; col_in = '0; rb_in = '0;
      end
      tot = sof ? 32'd0 : tot_ff;
      tot_in = tot;
      unique case (ph)
         tga_pkg::PH_HEADER: begin
            tot_in = {16'd0, w_ff} * {16'd0, h_ff};
            unique case (hc)
               5'd0:  il = req_data_byte;
               5'd2: begin
                  cd = req_data_byte == 8'd10;
                  to = req_data_byte == 8'd2 || req_data_byte == 8'd10;
               end
               5'd12: w[7:0] = req_data_byte;
               5'd13: w[15:8] = req_data_byte;
               5'd14: h[7:0] = req_data_byte;
               5'd15: h[15:8] = req_data_byte;
               5'd16: bp = (req_data_byte == 8'd24) ? 3'd3 :
                           (req_data_byte == 8'd32) ? 3'd4 : 3'd0;
               default: ;
            endcase
            hc = hc + 5'd1;
            if (hc >= 5'd18) begin
               hc = '0;
               if (!to) begin
                  ph = tga_pkg::PH_ERROR;
                  cmd.cmd = tga_pkg::CMD_STAT; cmd.status = tga_pkg::ST_BAD_TYPE;
               end else if (bp == 3'd0) begin
                  ph = tga_pkg::PH_ERROR;
                  cmd.cmd = tga_pkg::CMD_STAT; cmd.status = tga_pkg::ST_BAD_DEPTH;
               end else if (il != 8'd0) begin
                  ph = tga_pkg::PH_ID;
               end else begin
                  stp = 1'b1;
               end
            end
         end
         tga_pkg::PH_ID: begin
            if (il != 8'd0) il = il - 8'd1;
            if (il == 8'd0) stp = 1'b1;
         end
         tga_pkg::PH_PIXELS: begin
            if (cd && pl_ff == 8'd0) begin
               run_in = req_data_byte[7];
               pl_in = {1'b0, req_data_byte[6:0]} + 8'd1;
            end else begin
               asm_in = asm_ff | ({24'd0, req_data_byte} << {bi, 3'b000});
               bi = bi + 2'd1;
               if ({1'b0, bi} == bp || (bi == 2'd0 && bp == 3'd4)) begin
                  bi = '0;
                  cmd.pixel = {(bp == 3'd3) ? 8'hff : asm_in[31:24], asm_in[7:0],
                               asm_in[15:8], asm_in[23:16]};
                  asm_in = '0;
                  if (!cd) begin
                     cmd.cmd = tga_pkg::CMD_PIXEL;
                     cmd.index = rb_ff + {16'd0, col_ff};
                     npw = pw_ff + 32'd1;
                     col_in = col_ff + 16'd1;
                     if (col_in >= w) begin
                        col_in = '0;
                        rb_in = rb_ff - {16'd0, w};
                     end
                  end else if (run_ff) begin
                     cmd.cmd = tga_pkg::CMD_RUN;
                     cmd.index = pw_ff;
                     rem = tot - pw_ff;
                     take = ({24'd0, pl_ff} < rem) ? pl_ff : rem[7:0];
                     cmd.run_len = take;
                     npw = pw_ff + {24'd0, take};
                     pl_in = '0;
                  end else begin
                     cmd.cmd = tga_pkg::CMD_PIXEL;
                     cmd.index = pw_ff;
                     npw = pw_ff + 32'd1;
                     pl_in = pl_ff - 8'd1;
                  end
                  pw_in = npw;
                  cmd.done = npw == tot;
                  if (npw >= tot) ph = tga_pkg::PH_DONE;
               end
            end
         end
         default: ;
      endcase
      if (stp) begin
         asm_in = '0; bi = '0; pl_in = '0; run_in = 1'b0; pw_in = '0; col_in = '0;
         if (tot == 32'd0) begin
            ph = tga_pkg::PH_DONE;
            cmd.cmd = tga_pkg::CMD_STAT; cmd.status = tga_pkg::ST_OK; cmd.done = 1'b1;
         end else begin
            rb_in = tot - {16'd0, w};
            ph = tga_pkg::PH_PIXELS;
         end
      end
      cmd.width = w;
      cmd.height = h;
      phase_in = ph; hcnt_in = hc; idl_in = il; coded_in = cd; tok_in = to;
      bpp_in = bp; w_in = w; h_in = h; bip_in = bi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tga_pkg::PH_HEADER;
         hcnt_ff <= '0; idl_ff <= '0; coded_ff <= 1'b0; tok_ff <= 1'b0; bpp_ff <= '0;
         w_ff <= '0; h_ff <= '0; asm_ff <= '0; bip_ff <= '0; pl_ff <= '0;
         run_ff <= 1'b0; pw_ff <= '0; col_ff <= '0; rb_ff <= '0; tot_ff <= '0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; hcnt_ff <= hcnt_in; idl_ff <= idl_in;
            coded_ff <= coded_in; tok_ff <= tok_in; bpp_ff <= bpp_in;
            w_ff <= w_in; h_ff <= h_in; asm_ff <= asm_in; bip_ff <= bip_in;
            pl_ff <= pl_in; run_ff <= run_in; pw_ff <= pw_in; col_ff <= col_in;
            rb_ff <= rb_in; tot_ff <= tot_in;
         end
      end
   end
endmodule

[rtl/core/tga_back.sv]
//------------------------------------------------------------------------------
// tga_back
// Queues commands and expands them into results, up to two pixels each.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tga_truecolor_rle_decoder_core_defines.svh"
module tga_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  tga_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tga_pkg::rsp_type  rsp
);
   tga_pkg::cmd_type q_ff [tga_pkg::QueueDepth];
   logic [tga_pkg::QueueAw-1:0] wp_ff, rp_ff;
   logic [tga_pkg::QueueAw:0]   cnt_ff;
   logic [7:0]  left_ff, left_in;
   logic [31:0] idx_ff, idx_in;
   logic        busy_ff;
   tga_pkg::cmd_type head;
   logic [7:0]  rl;
   logic [31:0] ix;
   logic        pop, push, emit, fin;

   assign head = q_ff[rp_ff];
   assign cmd_ready = cnt_ff < (tga_pkg::QueueAw + 1)'(tga_pkg::QueueDepth - 1);
   assign push = cmd_valid;
   assign rl = busy_ff ? left_ff : head.run_len;
   assign ix = busy_ff ? idx_ff : head.index;
   assign rsp_valid = cnt_ff != '0;
   assign emit = rsp_valid && rsp_ready;
   assign fin = head.cmd != tga_pkg::CMD_RUN || rl <= 8'd2;
   assign pop = emit && fin;

   always_comb begin
      rsp.pixel_a = '0; rsp.pixel_b = '0; rsp.pixel_count = '0; rsp.pixel_index = '0;
      rsp.status = head.status;
      rsp.image_width = head.width;
      rsp.image_height = head.height;
      rsp.last = fin;
      rsp.image_done = head.done && fin;
      left_in = rl - 8'd2;
      idx_in = ix + 32'd2;
      unique case (head.cmd)
         tga_pkg::CMD_PIXEL: begin
            rsp.pixel_a = head.pixel; rsp.pixel_count = 2'd1; rsp.pixel_index = ix;
         end
         tga_pkg::CMD_RUN: begin
            rsp.pixel_a = head.pixel; rsp.pixel_index = ix;
            rsp.pixel_count = (rl >= 8'd2) ? 2'd2 : 2'd1;
            rsp.pixel_b = (rl >= 8'd2) ? head.pixel : 32'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cmd;
      if (emit) begin
         left_ff <= left_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; busy_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + {{tga_pkg::QueueAw{1'b0}}, push} -
                   {{tga_pkg::QueueAw{1'b0}}, pop};
         if (emit) busy_ff <= !fin;
      end
   end

   `TGA_ASSERT_IMP(a_no_overflow, clock, reset, push, cnt_ff < (tga_pkg::QueueAw + 1)'(tga_pkg::QueueDepth), "queue overflow")
   `TGA_ASSERT_IMP(a_busy_run, clock, reset, busy_ff && rsp_valid, head.cmd == tga_pkg::CMD_RUN, "busy on non-run")
   `TGA_ASSERT_NXT(a_pop_count, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1, "pop count")
endmodule

[rtl/core/tga_truecolor_rle_decoder_core.sv]
//------------------------------------------------------------------------------
// tga_truecolor_rle_decoder_core
// TGA truecolor decoder: raw and run-length images to RGBA results.
//------------------------------------------------------------------------------
// channel | ports | direction
// request | req_valid req_ready req_data_byte req_start_of_file | in
// result  | rsp_valid rsp_ready rsp_pixel_a .. rsp_last | out
// One request byte per cycle while the command queue has room.
// A run packet's pixel expands into ceil(n/2) results, one per cycle while rsp_ready is high.
// Requests stall when the four-entry command queue is nearly full.
// Synchronous reset returns the parser to header phase and empties the queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tga_truecolor_rle_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_a,
   output logic [31:0] rsp_pixel_b,
   output logic [1:0]  rsp_pixel_count,
   output logic [31:0] rsp_pixel_index,
   output logic [1:0]  rsp_status,
   output logic        rsp_image_done,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_last
);
   tga_pkg::cmd_type cmd;
   tga_pkg::rsp_type rsp;
   logic cmd_valid, cmd_ready;

   tga_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_start_of_file(req_start_of_file),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   tga_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   assign rsp_pixel_a = rsp.pixel_a;
   assign rsp_pixel_b = rsp.pixel_b;
   assign rsp_pixel_count = rsp.pixel_count;
   assign rsp_pixel_index = rsp.pixel_index;
   assign rsp_status = rsp.status;
   assign rsp_image_done = rsp.image_done;
   assign rsp_image_width = rsp.image_width;
   assign rsp_image_height = rsp.image_height;
   assign rsp_last = rsp.last;
endmodule
